// File: rtl/core/jcq_pkg.sv
package jcq_pkg;

  localparam int BLOCK_SIDE       = 8;
  localparam int BLOCK_CELLS      = BLOCK_SIDE * BLOCK_SIDE;
  localparam int POS_BITS         = $clog2(BLOCK_CELLS);
  localparam int COEF_BITS        = 16;
  localparam int COEF_FRAC_BITS   = 4;
  localparam int FACTOR_BITS      = 16;
  localparam int FACTOR_FRAC_BITS = 8;
  localparam int QTAB_BITS        = 7;

  localparam int MAG_BITS  = COEF_BITS;
  localparam int NUM_SHIFT = FACTOR_FRAC_BITS + 1 - COEF_FRAC_BITS;
  localparam int PROD_BITS = QTAB_BITS + FACTOR_BITS;
  localparam int NUM_BITS  =
    ((MAG_BITS + NUM_SHIFT > PROD_BITS) ? MAG_BITS + NUM_SHIFT : PROD_BITS) + 1;
  localparam int DIV_BITS  = PROD_BITS + 1;
  localparam int REM_BITS  = DIV_BITS;
  localparam int QUO_BITS  = MAG_BITS - 1 + NUM_SHIFT;
  localparam int LATENCY   = QUO_BITS + 3;

  localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = FACTOR_BITS'(1 << FACTOR_FRAC_BITS);
  localparam logic [FACTOR_BITS-1:0] FACTOR_MIN   = FACTOR_BITS'(1);
  localparam logic [QUO_BITS-1:0]    POS_LIMIT    = QUO_BITS'((1 << (COEF_BITS - 1)) - 1);
  localparam logic [QUO_BITS-1:0]    NEG_LIMIT    = QUO_BITS'(1 << (COEF_BITS - 1));

  localparam logic [QTAB_BITS-1:0] QTAB [2][BLOCK_CELLS] = '{
    '{
      7'd16, 7'd11, 7'd10, 7'd16, 7'd24,  7'd40,  7'd51,  7'd61,
      7'd12, 7'd12, 7'd14, 7'd19, 7'd26,  7'd58,  7'd60,  7'd55,
      7'd14, 7'd13, 7'd16, 7'd24, 7'd40,  7'd57,  7'd69,  7'd56,
      7'd14, 7'd17, 7'd22, 7'd29, 7'd51,  7'd87,  7'd80,  7'd62,
      7'd18, 7'd22, 7'd37, 7'd56, 7'd68,  7'd109, 7'd103, 7'd77,
      7'd24, 7'd35, 7'd55, 7'd64, 7'd81,  7'd104, 7'd113, 7'd92,
      7'd79, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
      7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
    },
    '{
      7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
      7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
      7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
      7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
      7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
      7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
      7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
      7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
    }
  };

  typedef struct packed {
    logic signed [COEF_BITS-1:0] coefficient;
    logic [POS_BITS-1:0]         position;
    logic                        table_select;
  } in_item_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] quantized;
    logic [POS_BITS-1:0]         position_out;
    logic                        saturated;
  } out_item_t;

  typedef struct packed {
    logic                neg;
    logic [POS_BITS-1:0] position;
    logic [REM_BITS-1:0] rem;
    logic [DIV_BITS-1:0] divisor;
    logic [QUO_BITS-1:0] bits;
  } div_item_t;

endpackage

// File: rtl/core/jcq_front.sv
module jcq_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            valid_in,
  input  jcq_pkg::in_item_t               item_in,
  input  logic [jcq_pkg::FACTOR_BITS-1:0] factor,
  output logic                            valid,
  output jcq_pkg::div_item_t              item
);

  logic                             valid1;
  logic                             neg1;
  logic [jcq_pkg::POS_BITS-1:0]     pos1;
  logic [jcq_pkg::MAG_BITS-1:0]     mag1;
  logic [jcq_pkg::PROD_BITS-1:0]    prod1;

  logic                             neg_in;
  logic [jcq_pkg::MAG_BITS-1:0]     mag_in;
  logic [jcq_pkg::QTAB_BITS-1:0]    q_in;
  logic [jcq_pkg::NUM_BITS-1:0]     num;
  jcq_pkg::div_item_t               item_next;

  assign neg_in = item_in.coefficient[jcq_pkg::COEF_BITS-1];
  assign mag_in = neg_in ? (jcq_pkg::MAG_BITS'(0) - jcq_pkg::MAG_BITS'(item_in.coefficient))
                         : jcq_pkg::MAG_BITS'(item_in.coefficient);
  assign q_in   = jcq_pkg::QTAB[item_in.table_select][item_in.position];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= valid_in;
    end
    neg1  <= neg_in;
    pos1  <= item_in.position;
    mag1  <= mag_in;
    prod1 <= jcq_pkg::PROD_BITS'(q_in) * jcq_pkg::PROD_BITS'(factor);
  end

  always_comb begin
    num = (jcq_pkg::NUM_BITS'(mag1) << jcq_pkg::NUM_SHIFT) + jcq_pkg::NUM_BITS'(prod1);
    item_next.neg      = neg1;
    item_next.position = pos1;
    item_next.rem      = jcq_pkg::REM_BITS'(num >> jcq_pkg::QUO_BITS);
    item_next.divisor  = {prod1, 1'b0};
    item_next.bits     = num[jcq_pkg::QUO_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid1;
    end
    item <= item_next;
  end

endmodule

// File: rtl/core/jcq_div_stage.sv
module jcq_div_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_in,
  input  jcq_pkg::div_item_t item_in,
  output logic               valid,
  output jcq_pkg::div_item_t item
);

  logic [jcq_pkg::REM_BITS:0] trial;
  logic [jcq_pkg::REM_BITS:0] diff;
  logic                       ge;
  jcq_pkg::div_item_t         item_next;

  always_comb begin
    trial = {item_in.rem, item_in.bits[jcq_pkg::QUO_BITS-1]};
    diff  = trial - {1'b0, item_in.divisor};
    ge    = trial >= {1'b0, item_in.divisor};
    item_next      = item_in;
    item_next.rem  = ge ? diff[jcq_pkg::REM_BITS-1:0] : trial[jcq_pkg::REM_BITS-1:0];
    item_next.bits = {item_in.bits[jcq_pkg::QUO_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_in;
    end
    item <= item_next;
  end

endmodule

// File: rtl/core/jcq_round_sat.sv
module jcq_round_sat (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_in,
  input  jcq_pkg::div_item_t item_in,
  output logic               valid,
  output jcq_pkg::out_item_t item
);

  logic [jcq_pkg::QUO_BITS-1:0]  limit;
  logic [jcq_pkg::QUO_BITS-1:0]  clipped;
  logic [jcq_pkg::COEF_BITS-1:0] mag;
  logic                          sat;
  jcq_pkg::out_item_t            item_next;

  always_comb begin
    limit   = item_in.neg ? jcq_pkg::NEG_LIMIT : jcq_pkg::POS_LIMIT;
    sat     = item_in.bits > limit;
    clipped = sat ? limit : item_in.bits;
    mag     = clipped[jcq_pkg::COEF_BITS-1:0];
    item_next.quantized    = item_in.neg ? (jcq_pkg::COEF_BITS'(0) - mag) : mag;
    item_next.position_out = item_in.position;
    item_next.saturated    = sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_in;
    end
    item <= item_next;
  end

endmodule

// File: rtl/core/jpeg_coefficient_quantizer_unit.sv
// Pipeline: a result strobes on done once the transaction accepted by start has passed all stages
// (two front stages, one divider stage per quotient bit, one rounding/saturation stage).
// Throughput: one transaction per cycle; busy is high only during reset.
// Reset: synchronous, clears all valid bits and sets quality_factor to 1.0 (256).
// The receiver cannot stall: each result is on result for exactly one cycle with done.
module jpeg_coefficient_quantizer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  jcq_pkg::in_item_t               data,
  output logic                            done,
  output jcq_pkg::out_item_t              result,
  input  logic                            quality_we,
  input  logic [jcq_pkg::FACTOR_BITS-1:0] quality_wdata
);

  logic [jcq_pkg::FACTOR_BITS-1:0] quality_factor;
  logic [jcq_pkg::FACTOR_BITS-1:0] factor;
  logic                            accept;

  logic               front_valid;
  jcq_pkg::div_item_t front_item;

  logic               stage_valid [jcq_pkg::QUO_BITS+1];
  jcq_pkg::div_item_t stage_item  [jcq_pkg::QUO_BITS+1];

  assign busy   = rst;
  assign accept = start && !busy;
  assign factor = (quality_factor == '0) ? jcq_pkg::FACTOR_MIN : quality_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      quality_factor <= jcq_pkg::FACTOR_RESET;
    end else if (quality_we) begin
      quality_factor <= quality_wdata;
    end
  end

  jcq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .valid_in (accept),
    .item_in  (data),
    .factor   (factor),
    .valid    (front_valid),
    .item     (front_item)
  );

  assign stage_valid[0] = front_valid;
  assign stage_item[0]  = front_item;

  for (genvar i = 0; i < jcq_pkg::QUO_BITS; i++) begin : g_div
    jcq_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .valid_in (stage_valid[i]),
      .item_in  (stage_item[i]),
      .valid    (stage_valid[i+1]),
      .item     (stage_item[i+1])
    );
  end

  jcq_round_sat u_round_sat (
    .clk      (clk),
    .rst      (rst),
    .valid_in (stage_valid[jcq_pkg::QUO_BITS]),
    .item_in  (stage_item[jcq_pkg::QUO_BITS]),
    .valid    (done),
    .item     (result)
  );

  a_done_from_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, jcq_pkg::LATENCY))
    else $error("result without an accepted transaction");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (done && result.saturated) |->
      (result.quantized == 16'sh7FFF || result.quantized == -16'sh8000))
    else $error("saturated result not at a limit");

  a_zero_coef: assert property (@(posedge clk) disable iff (rst)
    (done && $past(accept && data.coefficient == '0, jcq_pkg::LATENCY)) |->
      (result.quantized == '0 && !result.saturated))
    else $error("zero coefficient gave nonzero result");

endmodule
